FILE: hw/rtl/lrupr_pkg.sv
package lrupr_pkg;

    // build defaults
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 20;

    // fixed field widths
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 5;

    // register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_ACTIVE = 1'b0;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request, clear search
        logic issue;   // read one entry, advance index
        logic update;  // commit ages, fill slot, bump counters
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_issue;  // index on the read port is the last active slot
    } t_stat;

endpackage

FILE: hw/rtl/lrupr_ram.sv
module lrupr_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lrupr_ctrl.sv
module lrupr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_done,
    output lrupr_pkg::t_cmd o_cmd,
    input  lrupr_pkg::t_stat i_stat
);
    import lrupr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_UPDATE
    } t_state;

    t_state r_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_UPDATE);
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (i_stat.last_issue) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT:   r_state <= S_UPDATE;  // last compare lands
                S_UPDATE: r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.issue  = (r_state == S_ISSUE);
        o_cmd.update = (r_state == S_UPDATE);
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

FILE: hw/rtl/lrupr_dp.sv
module lrupr_dp #(
    parameter int MAX_ENTRIES = lrupr_pkg::MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lrupr_pkg::t_cmd                i_cmd,
    output lrupr_pkg::t_stat               o_stat,
    input  logic [lrupr_pkg::CFG_W-1:0]    i_active,
    input  logic [PAGE_BITS-1:0]           i_page,
    output logic                           o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]   o_slot,
    output logic [lrupr_pkg::CNT_W-1:0]    o_faults,
    output logic [lrupr_pkg::CNT_W-1:0]    o_requests
);
    import lrupr_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam logic [IW-1:0] AGE_MAX = IW'(MAX_ENTRIES - 1);
    localparam logic [NW-1:0] N_MAX   = NW'(MAX_ENTRIES);

    // request context
    logic [PAGE_BITS-1:0] r_page;
    logic [NW-1:0]        r_n;
    logic [NW-1:0]        n_n;
    logic [IW-1:0]        r_rd_idx;

    // compare stage, one behind the read port
    logic                 r_cmp_vld;
    logic [IW-1:0]        r_cmp_idx;
    logic [PAGE_BITS-1:0] rd_page;

    // search results
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_hit_age;
    logic          r_empty;
    logic [IW-1:0] r_empty_idx;
    logic [IW-1:0] r_best_age;
    logic [IW-1:0] r_best_idx;
    logic [IW-1:0] slot;

    // per-entry state
    logic          r_valid [MAX_ENTRIES];
    logic [IW-1:0] r_age   [MAX_ENTRIES];
    logic          n_valid [MAX_ENTRIES];
    logic [IW-1:0] n_age   [MAX_ENTRIES];

    logic          cur_valid;
    logic [IW-1:0] cur_age;

    logic [CNT_W-1:0] r_faults;
    logic [CNT_W-1:0] r_requests;
    logic             r_res_hit;
    logic [IW-1:0]    r_res_slot;
    logic [31:0]      slot_wide;

    // clamp active count to 1..MAX_ENTRIES
    always_comb begin
        if (i_active == '0) begin
            n_n = NW'(1);
        end else if (32'(i_active) > MAX_ENTRIES) begin
            n_n = N_MAX;
        end else begin
            n_n = NW'(i_active);
        end
    end

    assign o_stat.last_issue = ((NW'(r_rd_idx) + NW'(1)) == r_n);

    lrupr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update && !r_hit),
        .i_waddr (slot),
        .i_wdata (r_page),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_page)
    );

    assign cur_valid = r_valid[r_cmp_idx];
    assign cur_age   = r_age[r_cmp_idx];

    assign slot = r_hit ? r_hit_idx : (r_empty ? r_empty_idx : r_best_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page   <= i_page;
            r_n      <= n_n;
            r_rd_idx <= '0;
        end else if (i_cmd.issue) begin
            r_rd_idx <= r_rd_idx + IW'(1);
        end
        r_cmp_idx <= r_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
        end
    end

    // running search; first hit, first empty, oldest with lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit      <= 1'b0;
            r_empty    <= 1'b0;
            r_best_age <= '0;
            r_best_idx <= '0;
        end else if (r_cmp_vld) begin
            if (!r_hit && cur_valid && (rd_page == r_page)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_age <= cur_age;
            end
            if (!r_empty && !cur_valid) begin
                r_empty     <= 1'b1;
                r_empty_idx <= r_cmp_idx;
            end
            if (cur_age > r_best_age) begin
                r_best_age <= cur_age;
                r_best_idx <= r_cmp_idx;
            end
        end
    end

    // age update in every active entry at once
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_age[i]   = r_age[i];
            if (i_cmd.update && (NW'(i) < r_n)) begin
                if (IW'(i) == slot) begin
                    n_valid[i] = 1'b1;
                    n_age[i]   = '0;
                end else if (r_valid[i] && (!r_hit || (r_age[i] < r_hit_age))) begin
                    n_age[i] = (r_age[i] < AGE_MAX) ? r_age[i] + IW'(1) : AGE_MAX;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= '0;
            end
            r_faults   <= '0;
            r_requests <= '0;
        end else begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_valid[i] <= n_valid[i];
                r_age[i]   <= n_age[i];
            end
            if (i_cmd.update) begin
                if (r_requests != '1) begin
                    r_requests <= r_requests + CNT_W'(1);
                end
                if (!r_hit && (r_faults != '1)) begin
                    r_faults <= r_faults + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_hit  <= r_hit;
            r_res_slot <= slot;
        end
    end

    assign slot_wide  = 32'(r_res_slot);
    assign o_hit      = r_res_hit;
    assign o_slot     = slot_wide[SLOT_W-1:0];
    assign o_faults   = r_faults;
    assign o_requests = r_requests;

endmodule

FILE: hw/rtl/lru_page_replacement.sv
// LRU page store, fully associative, with least-recently-used replacement.
//
// Request channel: drive i_page_number and raise start; the transaction is
// taken at the clock edge where start is high and busy is low. One request
// is in flight at a time; busy stays high until its result is out.
// Result channel: o_done is high for exactly one cycle with o_hit, o_slot,
// o_fault_count and o_request_count valid; the receiver takes it in that
// cycle and cannot stall it.
// Sequence: with n the active entry count (clamped to 1..MAX_ENTRIES), the
// page tag RAM, whose single read port scans one entry per cycle, reads the
// n active entries in turn; then the last compare lands and the update
// commits ages, tag and counters. The result appears and busy drops in the
// same cycle, so a new request is taken only after the last one is through.
// Config: APB register 0 (address 0) is active_entries, reset value 16;
// write it only while busy is low. pready is tied high.
// Reset: synchronous, active low. Clears all valid bits, ages, counters and
// the controller; the page tag RAM itself is not cleared.
module lru_page_replacement #(
    parameter int MAX_ENTRIES = lrupr_pkg::MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic [PAGE_BITS-1:0]          i_page_number,
    // result
    output logic                          o_done,
    output logic                          o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]  o_slot,
    output logic [lrupr_pkg::CNT_W-1:0]   o_fault_count,
    output logic [lrupr_pkg::CNT_W-1:0]   o_request_count,
    // APB config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrupr_pkg::ADDR_W-1:0]  paddr,
    input  logic [lrupr_pkg::DATA_W-1:0]  pwdata,
    output logic [lrupr_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import lrupr_pkg::*;

    logic [CFG_W-1:0] r_active;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;

    // config register; index taken from the word address bit
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (cfg_wr && (paddr[2] == REG_ACTIVE)) begin
            r_active <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE) ? DATA_W'(r_active) : '0;

    lrupr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    lrupr_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_BITS   (PAGE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_active   (r_active),
        .i_page     (i_page_number),
        .o_hit      (o_hit),
        .o_slot     (o_slot),
        .o_faults   (o_fault_count),
        .o_requests (o_request_count)
    );

`ifndef SYNTHESIS
    // result only shows once the controller is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // faults never outnumber requests
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_fault_count <= o_request_count))
        else $error("fault count above request count");

    // a fault result always bumps the fault count unless saturated
    a_fault_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit && $past(o_fault_count) != '1)
            |-> (o_fault_count != $past(o_fault_count)))
        else $error("fault count did not advance on a miss");
`endif

endmodule

FILE: dv/tb_lru_page_replacement.sv
module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int NE = MAX_ENTRIES_DEF;
    localparam int PW = PAGE_BITS_DEF;
    localparam int AGE_W = $clog2(NE);

    localparam logic [ADDR_W-1:0] ADDR_ACTIVE = {REG_ACTIVE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = {~REG_ACTIVE, 2'b00};  // no register here

    localparam int TOTAL_ITEMS = 1370;       // directed plus random
    localparam int END_SETTLE  = 2 * NE + 8; // quiet cycles after the last result
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_MAX    = 40;

    // one result transaction as predicted
    typedef struct {
        bit              hit;
        bit [SLOT_W-1:0] slot;
        bit [CNT_W-1:0]  faults;
        bit [CNT_W-1:0]  requests;
    } t_outcome;

    // Mirrors the page store: tags, valid bits, ages, counters and the
    // active_entries register, and queues the outcome of each request.
    class lru_scoreboard;
        bit [PW-1:0]     tag  [NE];
        bit              held [NE];
        bit [AGE_W-1:0]  age  [NE];
        bit [CNT_W-1:0]  faults;
        bit [CNT_W-1:0]  requests;
        bit [CFG_W-1:0]  active_cfg;
        t_outcome        pending_outcomes[$];
        int              errors;

        function new();
            foreach (held[i]) begin
                held[i] = 1'b0;
                age[i]  = '0;
                tag[i]  = '0;
            end
            faults     = '0;
            requests   = '0;
            active_cfg = ACTIVE_RESET;
            errors     = 0;
        endfunction

        // 0 behaves as 1, anything above the depth as the depth
        function int live_slots();
            if (active_cfg == 0) return 1;
            if (active_cfg > NE) return NE;
            return active_cfg;
        endfunction

        function void write_reg(logic idx, logic [DATA_W-1:0] data);
            if (idx == REG_ACTIVE) active_cfg = data[CFG_W-1:0];
        endfunction

        function bit [AGE_W-1:0] older(bit [AGE_W-1:0] a);
            return (a < NE - 1) ? a + 1'b1 : AGE_W'(NE - 1);
        endfunction

        function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] c);
            return (c != '1) ? c + 1'b1 : c;
        endfunction

        // predict and apply one page reference
        function void note_request(logic [PW-1:0] page);
            int             n;
            int             way;
            bit             found;
            bit             gap_found;
            bit [AGE_W-1:0] prior;
            bit [AGE_W-1:0] oldest;
            t_outcome       o;
            n = live_slots();
            way = 0;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!found && held[i] && tag[i] == page) begin
                    found = 1'b1;
                    way = i;
                end
            end
            if (found) begin
                prior = age[way];
                for (int i = 0; i < n; i++)
                    if (held[i] && i != way && age[i] < prior) age[i] = older(age[i]);
                age[way] = '0;
            end else begin
                gap_found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!gap_found && !held[i]) begin
                        gap_found = 1'b1;
                        way = i;
                    end
                end
                if (!gap_found) begin
                    // evict the oldest; ties go to the lowest index
                    oldest = age[0];
                    way = 0;
                    for (int i = 1; i < n; i++) begin
                        if (age[i] > oldest) begin
                            oldest = age[i];
                            way = i;
                        end
                    end
                end
                for (int i = 0; i < n; i++)
                    if (held[i] && i != way) age[i] = older(age[i]);
                tag[way]  = page;
                held[way] = 1'b1;
                age[way]  = '0;
                faults    = bump(faults);
            end
            requests   = bump(requests);
            o.hit      = found;
            o.slot     = SLOT_W'(way);
            o.faults   = faults;
            o.requests = requests;
            pending_outcomes.push_back(o);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_outcome(logic hit, logic [SLOT_W-1:0] slot,
                                    logic [CNT_W-1:0] fc, logic [CNT_W-1:0] rc);
            t_outcome e;
            if (pending_outcomes.size() == 0) begin
                flag($sformatf("result with nothing pending: hit=%b slot=%0d", hit, slot));
                return;
            end
            e = pending_outcomes.pop_front();
            if (hit !== e.hit || slot !== e.slot || fc !== e.faults || rc !== e.requests)
                flag({$sformatf("result mismatch: exp hit=%b slot=%0d faults=%0d reqs=%0d",
                                e.hit, e.slot, e.faults, e.requests),
                      $sformatf(" / got hit=%b slot=%0d faults=%0d reqs=%0d",
                                hit, slot, fc, rc)});
        endfunction

        function void check_readback(logic [DATA_W-1:0] rd);
            if (rd !== DATA_W'(active_cfg))
                flag($sformatf("active_entries readback: exp %0d got %0d", active_cfg, rd));
        endfunction

        function void finish_check();
            if (pending_outcomes.size() != 0)
                flag($sformatf("%0d results never came", pending_outcomes.size()));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [PW-1:0]        i_page_number = '0;
    logic                 o_done;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_slot;
    logic [CNT_W-1:0]     o_fault_count;
    logic [CNT_W-1:0]     o_request_count;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    lru_scoreboard board;
    int            items_sent = 0;
    int            cycles = 0;

    lru_page_replacement i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_fault_count   (o_fault_count),
        .o_request_count (o_request_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Monitor: values read here are the ones settled before the edge.
    // The result is checked before a request taken on the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) board.check_outcome(o_hit, o_slot, o_fault_count, o_request_count);
            if (start && !busy) board.note_request(i_page_number);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sender idle share: 32%, then 67%, then none
    function int idle_pct();
        if (items_sent < TOTAL_ITEMS / 3) return 32;
        if (items_sent < 2 * TOTAL_ITEMS / 3) return 67;
        return 0;
    endfunction

    // one request transaction; start is redrawn every cycle against the
    // idle share until the block takes the request
    task automatic send_request(logic [PW-1:0] page);
        i_page_number <= page;
        do begin
            start <= ($urandom_range(99) >= idle_pct());
            @(posedge i_clk);
        end while (!(start && !busy));
        items_sent++;
    endtask

    // hold off until every predicted result has come back and the block is idle
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (board.pending_outcomes.size() != 0 || busy);
        @(posedge i_clk);
    endtask

    // APB write, then read back active_entries; call only when idle
    task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.write_reg(addr[2], data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ACTIVE;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.check_readback(prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [PW-1:0]     pool [POOL_MAX];
        int                pool_n;
        int                run_len;
        int                phase;
        logic [CFG_W-1:0]  cfg_val;
        logic [DATA_W-1:0] cfg_word;
        logic [PW-1:0]     page;

        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset depth of 16, fills, hits, page extremes
        send_request('0);
        send_request('1);
        send_request('0);
        send_request(PW'(20'hAAAAA));
        send_request(PW'(20'h55555));
        send_request('1);
        send_request(PW'(1));
        // two active slots: both full, so misses evict
        drain();
        cfg_write(ADDR_ACTIVE, 32'd2);
        send_request(PW'(20'h12345));
        send_request('1);
        send_request('0);
        send_request(PW'(20'h12345));
        // zero behaves as one slot
        drain();
        cfg_write(ADDR_ACTIVE, 32'd0);
        send_request('0);
        send_request('0);
        send_request(PW'(20'hABCDE));
        // write to an unmapped register leaves the depth alone
        drain();
        cfg_write(ADDR_UNUSED, 32'd3);
        send_request(PW'(20'hAAAAA));
        // over-range depth acts as full depth; hidden slots come back
        drain();
        cfg_write(ADDR_ACTIVE, '1);
        send_request(PW'(20'h55555));
        send_request(PW'(1));
        send_request(PW'(20'hFFFFE));
        send_request(PW'(20'h7FFFF));
        // only the low bits of the write data land in the register
        drain();
        cfg_write(ADDR_ACTIVE, 32'hA5A5_A5F0);
        send_request(PW'(20'h80000));

        // random phases: each with its own depth and a small working set,
        // so hits and evictions both happen often; some noise pages mixed in
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            drain();
            case (phase % 8)
                0: cfg_val = 5'd1;
                1: cfg_val = 5'd16;
                2: cfg_val = 5'd0;
                3: cfg_val = 5'd31;
                4: cfg_val = CFG_W'($urandom_range(17, 30));
                default: cfg_val = CFG_W'($urandom_range(2, 15));
            endcase
            if ($urandom_range(3) == 0) cfg_write(ADDR_UNUSED, $urandom());
            cfg_word = ($urandom_range(1) == 0) ? DATA_W'(cfg_val)
                                                : {(DATA_W-CFG_W)'($urandom()), cfg_val};
            cfg_write(ADDR_ACTIVE, cfg_word);

            pool_n = $urandom_range(1, 2 * board.live_slots() + 2);
            if (pool_n > POOL_MAX) pool_n = POOL_MAX;
            for (int i = 0; i < pool_n; i++) pool[i] = PW'($urandom());
            if ($urandom_range(1) == 0) pool[0] = '0;
            if (pool_n > 1 && $urandom_range(1) == 0) pool[1] = '1;

            run_len = $urandom_range(25, 60);
            for (int k = 0; k < run_len && items_sent < TOTAL_ITEMS; k++) begin
                if ($urandom_range(99) < 3) drain();
                if ($urandom_range(99) < 85) page = pool[$urandom_range(pool_n - 1)];
                else page = PW'($urandom());
                send_request(page);
            end
            phase++;
        end

        drain();
        repeat (END_SETTLE) @(posedge i_clk);
        board.finish_check();
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
